>>> rtl/core/tcon_pkg.sv
package tcon_pkg;

  localparam int COLS_DEF    = 70;
  localparam int ROWS_DEF    = 22;
  localparam int HISTORY_DEF = 200;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] ATTR_BLANK = 8'd7;
  localparam logic [15:0] BLANK_CELL = {ATTR_BLANK, CH_SP};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] row;
    logic [6:0] column;
    logic [7:0] view_back;
  } item_t;

endpackage

>>> rtl/core/tcon_queue.sv
module tcon_queue
  import tcon_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_take,
  output item_t out_item
);

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  logic push;
  logic pop;

  assign in_stall  = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/tcon_engine.sv
module tcon_engine
  import tcon_pkg::*;
#(
  parameter int COLS    = COLS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int HISTORY = HISTORY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_take,
  input  item_t      in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       cell_valid,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic [7:0] lines_saved
);

  localparam int SDEPTH = ROWS * COLS;
  localparam int HDEPTH = HISTORY * COLS;
  localparam int SAW = $clog2(SDEPTH);
  localparam int HAW = $clog2(HDEPTH);
  localparam int CW  = $clog2(COLS + 1);
  localparam int RW  = $clog2(ROWS + 1);
  localparam int HW  = $clog2(HISTORY + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_SCRL  = 4'd3;
  localparam logic [3:0] S_CLR   = 4'd4;
  localparam logic [3:0] S_DONE  = 4'd5;
  localparam logic [3:0] S_RDH   = 4'd6;
  localparam logic [3:0] S_INIT  = 4'd7;
  localparam logic [3:0] S_BLNK  = 4'd8;

  // memories
  logic [15:0] scr [SDEPTH];
  logic [15:0] hst [HDEPTH];
  logic [15:0] scr_q;
  logic [15:0] hst_q;

  logic [3:0]      state;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [HW-1:0]   hist_head;
  logic [HW-1:0]   hist_count;
  logic [SAW:0]    ptr;
  logic [HAW:0]    hptr;
  logic [CW-1:0]   ccnt;
  logic            sweep_ph;
  logic [SAW:0]    last_row_base;
  logic            sel_hist;
  logic            rd_ok;
  logic [SAW-1:0]  s_raddr;
  logic [SAW-1:0]  s_waddr;
  logic [15:0]     s_wdata;
  logic            s_wen;
  logic [HAW-1:0]  h_raddr;
  logic [HAW-1:0]  h_waddr;
  logic            h_wen;
  logic [15:0]     h_wdata;
  item_t           held;
  item_t           it;
  logic            out_free;

  // read address computation
  logic signed [HW+9:0] p;
  logic [HW+9:0]        up_s;
  logic [HW+9:0]        hrow;
  logic [SAW+8:0]       rowbase;

  assign out_free = !out_valid || !out_stall;
  assign in_take  = (state == S_IDLE) && in_valid && out_free;
  // the queue moves on after a take, so later states work on a held copy
  assign it       = (state == S_IDLE) ? in_item : held;
  assign last_row_base = (SAW + 1)'((ROWS - 1) * COLS);

  always_ff @(posedge clk) begin
    if (in_take) begin
      held <= in_item;
    end
  end

  always_comb begin
    p    = $signed({10'd0, hist_count}) + $signed((HW + 10)'(it.row))
           - $signed((HW + 10)'(it.view_back));
    up_s = p - (HW + 10)'(hist_count);
    hrow = (HW + 10)'(hist_head) + (HW + 10)'(HISTORY) - (HW + 10)'(hist_count)
           + (HW + 10)'(p);
    if (hrow >= (HW + 10)'(HISTORY)) begin
      hrow = hrow - (HW + 10)'(HISTORY);
    end
    rowbase = (SAW + 9)'(up_s) * (SAW + 9)'(COLS);
  end

  always_ff @(posedge clk) begin
    if (s_wen) begin
      scr[s_waddr] <= s_wdata;
    end
    scr_q <= scr[s_raddr];
    if (h_wen) begin
      hst[h_waddr] <= h_wdata;
    end
    hst_q <= hst[h_raddr];
  end

  // combinational memory control
  always_comb begin
    s_raddr = ptr[SAW-1:0];
    s_wen   = 1'b0;
    s_waddr = ptr[SAW-1:0];
    s_wdata = BLANK_CELL;
    h_wen   = 1'b0;
    h_waddr = hptr[HAW-1:0];
    h_wdata = scr_q;
    h_raddr = hptr[HAW-1:0];
    unique case (state)
      S_INIT, S_CLR, S_BLNK: begin
        s_wen = 1'b1;
      end
      S_SCRL: begin
        // ptr is read address; each read's data is written one row up in the following cycle
        if (sweep_ph) begin
          s_waddr = SAW'(ptr - (SAW + 1)'(COLS) - 1'b1);
          s_wen   = (ptr > (SAW + 1)'(COLS));
          s_wdata = scr_q;
          h_wen   = (ptr <= (SAW + 1)'(COLS));
        end
        if (ptr >= (SAW + 1)'(SDEPTH)) begin
          s_raddr = '0;
        end
      end
      S_RD1, S_RD2: begin
        // address held through S_RD1 and S_RD2 so the data is still there in S_RDH
        s_raddr = SAW'(rowbase + (SAW + 9)'(it.column));
        h_raddr = HAW'(hrow * (HW + 10)'(COLS) + (HW + 10)'(it.column));
      end
      default: begin
      end
    endcase
    if (state == S_IDLE && in_take && it.operation == OP_PUT) begin
      s_waddr = SAW'(cur_row * COLS + ((it.char_code == CH_BS) ?
                  cur_col - 1'b1 : cur_col));
      if (it.char_code == CH_BS) begin
        s_wen   = (cur_col != '0);
        s_wdata = {it.attribute, CH_SP};
      end else if (it.char_code != CH_LF && it.char_code != CH_CR &&
                   it.char_code != CH_TAB) begin
        s_wen   = 1'b1;
        s_wdata = {it.attribute, it.char_code};
      end
    end
  end

  // new-line helper values
  logic [CW-1:0] next_col;
  logic [CW-1:0] tab_col;
  logic          nl;

  always_comb begin
    tab_col  = (cur_col + CW'(8)) & ~CW'(7);
    next_col = cur_col;
    nl       = 1'b0;
    priority if (it.char_code == CH_LF) begin
      nl = 1'b1;
    end else if (it.char_code == CH_CR) begin
      next_col = '0;
    end else if (it.char_code == CH_BS) begin
      if (cur_col != '0) begin
        next_col = cur_col - 1'b1;
      end
    end else if (it.char_code == CH_TAB) begin
      next_col = tab_col;
      nl = (tab_col >= CW'(COLS));
    end else begin
      next_col = cur_col + 1'b1;
      nl = (next_col >= CW'(COLS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      hist_head  <= '0;
      hist_count <= '0;
      ptr        <= '0;
      hptr       <= '0;
      out_valid  <= 1'b0;
      sweep_ph   <= 1'b0;
      ccnt       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT, S_CLR: begin
          ptr <= ptr + 1'b1;
          if (ptr == (SAW + 1)'(SDEPTH - 1)) begin
            ptr <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            cell_char  <= '0;
            cell_attr  <= '0;
            cell_valid <= 1'b0;
            unique case (it.operation)
              OP_READ: begin
                state <= S_RD1;
              end
              OP_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                ptr     <= '0;
                state   <= S_CLR;
              end
              OP_PUT: begin
                cur_col <= nl ? '0 : next_col;
                if (nl && cur_row == RW'(ROWS - 1)) begin
                  ptr      <= '0;
                  hptr     <= (HAW + 1)'(hist_head * COLS);
                  sweep_ph <= 1'b0;
                  state    <= S_SCRL;
                end else begin
                  if (nl) begin
                    cur_row <= cur_row + 1'b1;
                  end
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD1: begin
          sel_hist <= (p >= 0) && (p < $signed((HW + 10)'(hist_count)));
          rd_ok    <= (it.column < 7'(COLS)) && (p >= 0) &&
                      (up_s < (HW + 10)'(ROWS) || p < $signed((HW + 10)'(hist_count)));
          state    <= S_RD2;
        end
        S_RD2: begin
          state <= S_RDH;
        end
        S_RDH: begin
          cell_valid <= rd_ok;
          if (rd_ok) begin
            {cell_attr, cell_char} <= sel_hist ? hst_q : scr_q;
          end
          state <= S_DONE;
        end
        S_SCRL: begin
          // one read per cycle; data arrives next cycle and is written
          sweep_ph <= 1'b1;
          if (sweep_ph && ptr <= (SAW + 1)'(COLS)) begin
            hptr <= hptr + 1'b1;
          end
          if (ptr < (SAW + 1)'(SDEPTH)) begin
            ptr <= ptr + 1'b1;
          end else begin
            // tail: blank the bottom row
            ptr   <= last_row_base;
            ccnt  <= '0;
            state <= S_BLNK;
          end
        end
        S_BLNK: begin
          ptr  <= ptr + 1'b1;
          ccnt <= ccnt + 1'b1;
          if (ccnt == CW'(COLS - 1)) begin
            hist_head <= (hist_head == HW'(HISTORY - 1)) ? '0 : hist_head + 1'b1;
            if (hist_count != HW'(HISTORY)) begin
              hist_count <= hist_count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cursor_col  = 7'(cur_col);
  assign cursor_row  = 5'(cur_row);
  assign lines_saved = 8'(hist_count);

endmodule

>>> rtl/core/text_console_with_scrollback.sv
// text console with scroll-back history
// input channel: in_valid/in_stall with operation, char_code, attribute,
//   row, column, view_back; operation 0 puts a character, 1 reads one
//   visible cell at a scroll-back offset, 2 clears the screen
// output channel: out_valid/out_stall, one item per accepted item carrying
//   the read cell, its valid flag, cursor position and history line count
// a two-entry queue decouples the front end from the execution engine
// the engine takes a new item only when it is idle, so each item is
//   finished before the next one is taken from the queue
// a new line past the bottom row copies the whole screen up one row,
//   one cell per cycle through the screen memory port, then blanks the
//   bottom row; a clear writes blanks to every screen cell
// after reset the screen memory is filled with blanks, and no item is
//   taken by the engine until the fill is done
// when the receiver stalls, the finished item holds and the engine stops
module text_console_with_scrollback
  import tcon_pkg::*;
#(
  parameter int COLS    = COLS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int HISTORY = HISTORY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  input  logic [7:0] attribute,
  input  logic [4:0] row,
  input  logic [6:0] column,
  input  logic [7:0] view_back,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       cell_valid,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic [7:0] lines_saved
);

  item_t q_in;
  item_t q_out;
  logic  q_valid;
  logic  q_take;

  // front end: pack the item
  assign q_in = '{operation: operation, char_code: char_code, attribute: attribute,
                  row: row, column: column, view_back: view_back};

  tcon_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (q_in),
    .out_valid (q_valid),
    .out_take  (q_take),
    .out_item  (q_out)
  );

  // back end: executes one item at a time
  tcon_engine #(
    .COLS    (COLS),
    .ROWS    (ROWS),
    .HISTORY (HISTORY)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_take     (q_take),
    .in_item     (q_out),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_char   (cell_char),
    .cell_attr   (cell_attr),
    .cell_valid  (cell_valid),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .lines_saved (lines_saved)
  );

endmodule
